// ----- rtl/ims_pkg.sv -----
// Package for the icosphere midpoint subdivider: payload structs, command and status codes.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ims_pkg;

    localparam int VERTEX_DEPTH_DEF   = 4096;
    localparam int MIDPOINT_DEPTH_DEF = 2048;
    localparam int COORD_BITS_DEF     = 32;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [2:0] CMD_LOAD      = 3'd0;
    localparam logic [2:0] CMD_SUBDIVIDE = 3'd1;
    localparam logic [2:0] CMD_END_PASS  = 3'd2;
    localparam logic [2:0] CMD_READ      = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_VERT_FULL  = 2'd1;
    localparam logic [1:0] ST_MID_FULL   = 2'd2;
    localparam logic [1:0] ST_NOT_LOADED = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic [11:0]        index_a;
        logic [11:0]        index_b;
        logic [11:0]        index_c;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic [12:0]        corner_first;
        logic [11:0]        corner_second;
        logic [11:0]        corner_third;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         status;
        logic               last;
    } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/icosphere_midpoint_subdivider.sv -----
// Top level of the icosphere midpoint subdivider.
// Channels: in (valid/ready, ims_pkg::in_item_t) and out (valid/ready, ims_pkg::out_item_t).
// Each transfer on in carries one command; load, end pass, read, and clear give one
// result, a subdivide gives four triangles or one error result, with last on the final one.
// Codes five to seven are dropped by the front end and give no result.
// A subdivide is paced by the back end walking the midpoint table one entry per cycle through
// its single read port.
// A two-entry queue separates the front end from the back end.
// Reset clears the vertex and midpoint counts; store contents stay undefined and are never
// read before they are written.
// When the receiver stalls, the held result waits in the output register and the back end
// stops; the queue keeps taking transfers until it is full.
`timescale 1ns / 1ps
`default_nettype none
module icosphere_midpoint_subdivider #(
    parameter int VERTEX_DEPTH   = ims_pkg::VERTEX_DEPTH_DEF,
    parameter int MIDPOINT_DEPTH = ims_pkg::MIDPOINT_DEPTH_DEF,
    parameter int COORD_BITS     = ims_pkg::COORD_BITS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  ims_pkg::in_item_t  in_data,
    input  wire                in_valid,
    output logic               in_ready,
    output ims_pkg::out_item_t out_data,
    output logic               out_valid,
    input  wire                out_ready
);

    ims_pkg::in_item_t q_data;
    logic              q_valid;
    logic              q_ready;

    ims_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_data   (q_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready)
    );

    ims_back #(
        .VERTEX_DEPTH   (VERTEX_DEPTH),
        .MIDPOINT_DEPTH (MIDPOINT_DEPTH),
        .COORD_BITS     (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ims_pkg::ST_OK |-> out_data.last)
        else $error("Error result without last.");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ims_pkg::ST_OK |-> out_data.corner_first == 13'd0)
        else $error("Error result carries an index.");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |-> !out_valid || out_ready)
        else $error("Back end took a command while a result was blocked.");

endmodule
`default_nettype wire

// ----- rtl/ims_front.sv -----
// Front end of the subdivider: accepts commands, drops unused codes, and queues the rest.
// Depends on ims_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ims_front (
    input  wire                clk,
    input  wire                rst_n,
    input  ims_pkg::in_item_t  in_data,
    input  wire                in_valid,
    output logic               in_ready,
    output ims_pkg::in_item_t  q_data,
    output logic               q_valid,
    input  wire                q_ready
);

    ims_pkg::in_item_t mem_reg [ims_pkg::QUEUE_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop, legal;

    assign legal    = (in_data.command <= ims_pkg::CMD_CLEAR);
    assign in_ready = (cnt_reg != 2'(ims_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready && legal;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ims_back.sv -----
// Back end of the subdivider: vertex store, midpoint table, sequential search and result output.
// Depends on ims_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ims_back #(
    parameter int VERTEX_DEPTH   = ims_pkg::VERTEX_DEPTH_DEF,
    parameter int MIDPOINT_DEPTH = ims_pkg::MIDPOINT_DEPTH_DEF,
    parameter int COORD_BITS     = ims_pkg::COORD_BITS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  ims_pkg::in_item_t  q_data,
    input  wire                q_valid,
    output logic               q_ready,
    output ims_pkg::out_item_t out_data,
    output logic               out_valid,
    input  wire                out_ready
);

    localparam int VAW = $clog2(VERTEX_DEPTH);
    localparam int MAW = $clog2(MIDPOINT_DEPTH);
    localparam int VCW = $clog2(VERTEX_DEPTH + 1);
    localparam int MCW = $clog2(MIDPOINT_DEPTH + 1);
    localparam int PW  = 3 * COORD_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDA   = 4'd1;
    localparam logic [3:0] S_RDB   = 4'd2;
    localparam logic [3:0] S_RDC   = 4'd3;
    localparam logic [3:0] S_MID   = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_CHECK = 4'd6;
    localparam logic [3:0] S_APP   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_RDWT  = 4'd10;

    logic [PW-1:0]  vmem [VERTEX_DEPTH];
    logic [PW-1:0]  kmem [MIDPOINT_DEPTH];
    logic [VAW-1:0] imem [MIDPOINT_DEPTH];

    logic [PW-1:0]  vrd_reg;
    logic [PW-1:0]  krd_reg;
    logic [VAW-1:0] ird_reg;
    logic           krd_ok_reg, krd_ok_next;

    logic [3:0]     state_reg, state_next;
    logic [VCW-1:0] vcount_reg, vcount_next;
    logic [MCW-1:0] mcount_reg, mcount_next;
    ims_pkg::in_item_t item_reg;
    logic [PW-1:0]  pa_reg, pb_reg;
    logic [PW-1:0]  mid_reg [3];
    logic [VAW-1:0] idx_reg [3];
    logic [VAW-1:0] idx_next [3];
    logic [2:0]     found_reg, found_next;
    logic [MCW-1:0] scan_reg, scan_next;
    logic [1:0]     app_reg, app_next;
    logic [1:0]     emit_reg, emit_next;
    ims_pkg::out_item_t res_reg, res_next;
    logic           res_valid_reg, res_valid_next;

    logic           v_we, k_we;
    logic [VAW-1:0] v_waddr, v_raddr;
    logic [MAW-1:0] k_waddr;
    logic [PW-1:0]  v_wdata;

    function automatic logic [PW-1:0] mid_of(input logic [PW-1:0] p, input logic [PW-1:0] q);
        logic [PW-1:0] m;
        logic signed [COORD_BITS:0] s;
        for (int k = 0; k < 3; k++)
        begin
            s = $signed({p[k*COORD_BITS + COORD_BITS-1], p[k*COORD_BITS +: COORD_BITS]})
              + $signed({q[k*COORD_BITS + COORD_BITS-1], q[k*COORD_BITS +: COORD_BITS]});
            m[k*COORD_BITS +: COORD_BITS] = s[COORD_BITS:1];
        end
        return m;
    endfunction

    function automatic logic signed [31:0] sx(input logic [COORD_BITS-1:0] v);
        return 32'($signed(v));
    endfunction

    function automatic logic [12:0] vx(input logic [VAW-1:0] v);
        return 13'(v);
    endfunction

    logic [1:0] need;
    logic       bad_sub;
    logic       res_free;
    logic       vfull;
    logic [1:0] app_k;

    assign vfull    = (vcount_reg >= VCW'(VERTEX_DEPTH));
    assign need     = 2'(!found_reg[0]) + 2'(!found_reg[1]) + 2'(!found_reg[2]);
    assign bad_sub  = ({1'b0, item_reg.index_a} >= 13'(vcount_reg))
                   || ({1'b0, item_reg.index_b} >= 13'(vcount_reg))
                   || ({1'b0, item_reg.index_c} >= 13'(vcount_reg));
    assign res_free = !res_valid_reg || out_ready;
    assign q_ready  = (state_reg == S_IDLE) && res_free;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;
    assign app_k     = app_reg;

    always_comb
    begin
        v_raddr = VAW'(item_reg.index_a);
        case (state_reg)
            S_IDLE:  v_raddr = VAW'(q_data.index_a);
            S_RDA:   v_raddr = VAW'(item_reg.index_b);
            S_RDB:   v_raddr = VAW'(item_reg.index_c);
            default: v_raddr = VAW'(item_reg.index_a);
        endcase
    end

    always_comb
    begin
        v_we    = 1'b0;
        k_we    = 1'b0;
        v_waddr = VAW'(vcount_reg);
        k_waddr = MAW'(mcount_reg);
        v_wdata = {q_data.coord_z[COORD_BITS-1:0], q_data.coord_y[COORD_BITS-1:0],
                   q_data.coord_x[COORD_BITS-1:0]};
        if (state_reg == S_IDLE && q_valid && res_free && q_data.command == ims_pkg::CMD_LOAD
            && !vfull)
        begin
            v_we = 1'b1;
        end
        if (state_reg == S_APP && !found_reg[app_k])
        begin
            v_we    = 1'b1;
            k_we    = 1'b1;
            v_wdata = mid_reg[app_k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vmem[v_waddr] <= v_wdata;
        end
        vrd_reg <= vmem[v_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            kmem[k_waddr] <= v_wdata;
            imem[k_waddr] <= VAW'(vcount_reg);
        end
        krd_reg <= kmem[MAW'(scan_reg)];
        ird_reg <= imem[MAW'(scan_reg)];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && res_free)
                begin
                    item_reg <= q_data;
                end
            end
            S_RDA:   pa_reg <= vrd_reg;
            S_RDB:   pb_reg <= vrd_reg;
            S_RDC:
            begin
                mid_reg[0] <= mid_of(pa_reg, pb_reg);
                mid_reg[1] <= mid_of(pb_reg, vrd_reg);
                mid_reg[2] <= mid_of(vrd_reg, pa_reg);
            end
            default: pa_reg <= pa_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        vcount_next    = vcount_reg;
        mcount_next    = mcount_reg;
        found_next     = found_reg;
        scan_next      = scan_reg;
        app_next       = app_reg;
        emit_next      = emit_reg;
        krd_ok_next    = krd_ok_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !out_ready;
        for (int k = 0; k < 3; k++)
        begin
            idx_next[k] = idx_reg[k];
        end
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && res_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    res_next.last  = 1'b1;
                    case (q_data.command)
                        ims_pkg::CMD_LOAD:
                        begin
                            if (vfull)
                            begin
                                res_next.status = ims_pkg::ST_VERT_FULL;
                            end
                            else
                            begin
                                res_next.corner_first = 13'(vcount_reg);
                                vcount_next = vcount_reg + 1'b1;
                            end
                        end
                        ims_pkg::CMD_END_PASS:
                        begin
                            mcount_next = '0;
                            res_next.corner_first = 13'(vcount_reg);
                        end
                        ims_pkg::CMD_CLEAR:
                        begin
                            mcount_next = '0;
                            vcount_next = '0;
                        end
                        ims_pkg::CMD_READ:
                        begin
                            res_valid_next = 1'b0;
                            state_next     = S_RDWT;
                        end
                        ims_pkg::CMD_SUBDIVIDE:
                        begin
                            res_valid_next = 1'b0;
                            state_next     = S_RDA;
                        end
                        default: res_valid_next = 1'b0;
                    endcase
                end
            end
            S_RDWT:
            begin
                res_valid_next = 1'b1;
                res_next       = '0;
                res_next.last  = 1'b1;
                if ({1'b0, item_reg.index_a} >= 13'(vcount_reg))
                begin
                    res_next.status = ims_pkg::ST_NOT_LOADED;
                end
                else
                begin
                    res_next.corner_first = {1'b0, item_reg.index_a};
                    res_next.out_x = sx(vrd_reg[0 +: COORD_BITS]);
                    res_next.out_y = sx(vrd_reg[COORD_BITS +: COORD_BITS]);
                    res_next.out_z = sx(vrd_reg[2*COORD_BITS +: COORD_BITS]);
                end
                state_next = S_IDLE;
            end
            S_RDA:
            begin
                if (bad_sub)
                begin
                    res_valid_next  = 1'b1;
                    res_next        = '0;
                    res_next.last   = 1'b1;
                    res_next.status = ims_pkg::ST_NOT_LOADED;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_RDB;
                end
            end
            S_RDB: state_next = S_RDC;
            S_RDC: state_next = S_MID;
            S_MID:
            begin
                found_next  = '0;
                scan_next   = '0;
                krd_ok_next = 1'b0;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                if (krd_ok_reg)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (krd_reg == mid_reg[k])
                        begin
                            found_next[k] = 1'b1;
                            idx_next[k]   = ird_reg;
                        end
                    end
                end
                if (scan_reg < mcount_reg)
                begin
                    krd_ok_next = 1'b1;
                    scan_next   = scan_reg + 1'b1;
                end
                else
                begin
                    krd_ok_next = 1'b0;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                app_next = '0;
                if (32'(vcount_reg) + 32'(need) > 32'(VERTEX_DEPTH))
                begin
                    res_valid_next  = 1'b1;
                    res_next        = '0;
                    res_next.last   = 1'b1;
                    res_next.status = ims_pkg::ST_VERT_FULL;
                    state_next      = S_IDLE;
                end
                else if (32'(mcount_reg) + 32'(need) > 32'(MIDPOINT_DEPTH))
                begin
                    res_valid_next  = 1'b1;
                    res_next        = '0;
                    res_next.last   = 1'b1;
                    res_next.status = ims_pkg::ST_MID_FULL;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_APP;
                end
            end
            S_APP:
            begin
                if (!found_reg[app_k])
                begin
                    idx_next[app_k] = VAW'(vcount_reg);
                    vcount_next     = vcount_reg + 1'b1;
                    mcount_next     = mcount_reg + 1'b1;
                end
                if (app_reg == 2'd2)
                begin
                    emit_next  = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    app_next = app_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    case (emit_reg)
                        2'd0:
                        begin
                            res_next.corner_first  = {1'b0, item_reg.index_a};
                            res_next.corner_second = 12'(idx_reg[0]);
                            res_next.corner_third  = 12'(idx_reg[2]);
                        end
                        2'd1:
                        begin
                            res_next.corner_first  = vx(idx_reg[2]);
                            res_next.corner_second = 12'(idx_reg[1]);
                            res_next.corner_third  = item_reg.index_c;
                        end
                        2'd2:
                        begin
                            res_next.corner_first  = vx(idx_reg[0]);
                            res_next.corner_second = item_reg.index_b;
                            res_next.corner_third  = 12'(idx_reg[1]);
                        end
                        default:
                        begin
                            res_next.corner_first  = vx(idx_reg[0]);
                            res_next.corner_second = 12'(idx_reg[1]);
                            res_next.corner_third  = 12'(idx_reg[2]);
                            res_next.last          = 1'b1;
                            state_next             = S_IDLE;
                        end
                    endcase
                    emit_next = emit_reg + 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= '0;
            mcount_reg    <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            found_reg     <= '0;
            scan_reg      <= '0;
            app_reg       <= '0;
            emit_reg      <= '0;
            krd_ok_reg    <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                idx_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            mcount_reg    <= mcount_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
            found_reg     <= found_next;
            scan_reg      <= scan_next;
            app_reg       <= app_next;
            emit_reg      <= emit_next;
            krd_ok_reg    <= krd_ok_next;
            for (int k = 0; k < 3; k++)
            begin
                idx_reg[k] <= idx_next[k];
            end
        end
    end

endmodule
`default_nettype wire
